FILE: design/assert_macros.svh
// Assertion helpers shared by the flood-fill RTL.
// Every user must have clk_i and rst_ni (active low) in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at each rising clock edge, ignored while reset is held.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, expr) \
  `ASSERT_CLK(label, !(expr))

`endif

FILE: design/bffm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the flood-fill block.
// No dependencies; used by bffm_ctrl, bffm_dp and the top level.
package bffm_pkg;

  // Item opcodes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_FILL  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Port field widths
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned COORD_W  = 7;
  localparam int unsigned COUNT_W  = 15;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7FFF;

  // Coordinates widened so that image sizes up to 1024 compare cleanly
  localparam int unsigned COORD_EXT_W = 11;

  // Direction counter: runs 0..8
  localparam int unsigned DIR_W = 4;
  localparam logic [DIR_W-1:0] DIRS_FOUR  = 4'd4;
  localparam logic [DIR_W-1:0] DIRS_EIGHT = 4'd8;

  // Step codes per axis
  typedef logic [1:0] step_t;
  localparam step_t STEP_ZERO = 2'd0;
  localparam step_t STEP_POS  = 2'd1;
  localparam step_t STEP_NEG  = 2'd3;

  // Orthogonal neighbours first, diagonals after
  localparam step_t STEP_DC [8] = '{STEP_POS, STEP_NEG, STEP_ZERO, STEP_ZERO,
                                    STEP_POS, STEP_POS, STEP_NEG, STEP_NEG};
  localparam step_t STEP_DR [8] = '{STEP_ZERO, STEP_ZERO, STEP_POS, STEP_NEG,
                                    STEP_POS, STEP_NEG, STEP_POS, STEP_NEG};

  // Controller to datapath commands
  typedef struct packed {
    logic sweep_wr;    // clear one visited entry after reset
    logic item_acc;    // load / query / unused item taken
    logic is_load;
    logic is_query;
    logic fill_acc;    // fill item taken: capture start pixel
    logic clr_reset;   // restart the mask clear pointer
    logic clr_rd;      // read queue entry to clear
    logic clr_wr;      // clear visited bit of that entry
    logic tail_clr;    // empty the queue
    logic start_rd;    // read wall bit of start pixel
    logic start_mark;  // mark and enqueue start pixel
    logic pop_rd;      // read queue head
    logic cen_load;    // take head as centre pixel
    logic nbr_rd;      // read wall and visited of neighbour
    logic nbr_mark;    // mark and enqueue neighbour
    logic dir_inc;
    logic s1_out;      // move load/query result into output register
    logic res_load;    // move fill result into output register
    logic abort;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sweep_last;
    logic clr_done;
    logic start_inside;
    logic start_wall;
    logic queue_empty;
    logic center_corner;
    logic dir_done;
    logic nbr_inside;
    logic nbr_free;
  } stat_t;

endpackage

FILE: design/bfs_flood_fill_mask.sv
`timescale 1ns / 1ps
// Flood-fill region finder, top level: sequencer plus datapath.
// Depends on bffm_pkg, bffm_ctrl, bffm_dp (and bffm_ram below it).
//
// Usage
//   Input channel (in_valid_i/in_ready_o) carries opcode, col, row, wall:
//   load writes one wall bit, fill walks breadth-first from (col,row) over
//   non-wall pixels and builds the mask, query reads one mask bit.
//   Output channel (out_valid_o/out_ready_i) returns exactly one transfer per
//   input transfer: status, mask_bit, fill_count.
//   cfg_we_i/cfg_wdata_i write neighbour mode (0: four, 1: eight); write only
//   while the block is idle.
// Operation
//   Load and query: one transfer per cycle while the output is not stalled;
//   the result passes through a staging register and the output register.
//   Fill: wipes the mask from the queue of pixels marked by the previous fill,
//   checks the start pixel, then for each dequeued pixel visits its in-image
//   neighbours, then posts the result (empty-queue check, output load). An
//   abort also wipes the pixels already marked. Bound by the single read
//   port of each memory.
// Reset
//   After reset all 2^(CW+RW) visited entries (16384 at 128 x 128) are
//   cleared one entry a cycle; no input is taken until it finishes.
//   A stalled receiver holds the output register; a load or query may still
//   be staged behind it, after which input stalls.
module bfs_flood_fill_mask #(
  parameter int unsigned IMAGE_WIDTH  = 128,
  parameter int unsigned IMAGE_HEIGHT = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input item transfer
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bffm_pkg::OPCODE_W-1:0] opcode_i,
  input  logic [bffm_pkg::COORD_W-1:0]  col_i,
  input  logic [bffm_pkg::COORD_W-1:0]  row_i,
  input  logic                          wall_i,
  // result transfer
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          status_o,
  output logic                          mask_bit_o,
  output logic [bffm_pkg::COUNT_W-1:0]  fill_count_o,
  // neighbour mode register
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i
);

  bffm_pkg::cmd_t  cmd;
  bffm_pkg::stat_t stat;

  // sequencer: handshakes, fill walk control
  bffm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // memories, queue pointers, neighbour generation, result register
  bffm_dp #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .col_i        (col_i),
    .row_i        (row_i),
    .wall_i       (wall_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .status_o     (status_o),
    .mask_bit_o   (mask_bit_o),
    .fill_count_o (fill_count_o)
  );

endmodule

FILE: design/bffm_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bffm_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/bffm_ctrl.sv
`timescale 1ns / 1ps
// Flood-fill sequencer: handshakes, result staging and walk control.
// Depends on bffm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bffm_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bffm_pkg::OPCODE_W-1:0] opcode_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  bffm_pkg::stat_t               stat_i,
  output bffm_pkg::cmd_t                cmd_o
);

  localparam logic [3:0] S_RSWEEP = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CLR_RD = 4'd2;
  localparam logic [3:0] S_CLR_WR = 4'd3;
  localparam logic [3:0] S_START  = 4'd4;
  localparam logic [3:0] S_SCHK   = 4'd5;
  localparam logic [3:0] S_POP    = 4'd6;
  localparam logic [3:0] S_CEN    = 4'd7;
  localparam logic [3:0] S_NRD    = 4'd8;
  localparam logic [3:0] S_NCHK   = 4'd9;
  localparam logic [3:0] S_RESULT = 4'd10;

  logic [3:0] state_q, state_d;
  logic       abort_q, abort_d;
  logic       s1_valid_q, s1_valid_d;
  logic       out_valid_q, out_valid_d;
  logic       s1_adv, in_ready, accept;
  bffm_pkg::cmd_t cmd;

  assign s1_adv   = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready = (state_q == S_IDLE) && (!s1_valid_q || s1_adv);
  assign accept   = in_valid_i && in_ready;

  always_comb begin
    cmd         = '0;
    state_d     = state_q;
    abort_d     = abort_q;
    cmd.abort   = abort_q;
    cmd.s1_out  = s1_adv;
    unique case (state_q)
      S_RSWEEP: begin
        cmd.sweep_wr = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (opcode_i == bffm_pkg::OP_FILL) begin
            cmd.fill_acc  = 1'b1;
            cmd.clr_reset = 1'b1;
            abort_d       = 1'b0;
            state_d       = S_CLR_RD;
          end else begin
            cmd.item_acc = 1'b1;
            cmd.is_load  = (opcode_i == bffm_pkg::OP_LOAD);
            cmd.is_query = (opcode_i == bffm_pkg::OP_QUERY);
          end
        end
      end
      S_CLR_RD: begin
        if (stat_i.clr_done) begin
          if (abort_q) begin
            cmd.tail_clr = 1'b1;
            state_d      = S_RESULT;
          end else begin
            state_d = S_START;
          end
        end else begin
          cmd.clr_rd = 1'b1;
          state_d    = S_CLR_WR;
        end
      end
      S_CLR_WR: begin
        cmd.clr_wr = 1'b1;
        state_d    = S_CLR_RD;
      end
      S_START: begin
        cmd.tail_clr = 1'b1;
        if (stat_i.start_inside) begin
          cmd.start_rd = 1'b1;
          state_d      = S_SCHK;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_SCHK: begin
        if (stat_i.start_wall) begin
          state_d = S_RESULT;
        end else begin
          cmd.start_mark = 1'b1;
          state_d        = S_POP;
        end
      end
      S_POP: begin
        if (stat_i.queue_empty) begin
          state_d = S_RESULT;
        end else begin
          cmd.pop_rd = 1'b1;
          state_d    = S_CEN;
        end
      end
      S_CEN: begin
        if (stat_i.center_corner) begin
          // corner reached: wipe the mask before reporting
          abort_d       = 1'b1;
          cmd.clr_reset = 1'b1;
          state_d       = S_CLR_RD;
        end else begin
          cmd.cen_load = 1'b1;
          state_d      = S_NRD;
        end
      end
      S_NRD: begin
        if (stat_i.dir_done) begin
          state_d = S_POP;
        end else if (stat_i.nbr_inside) begin
          cmd.nbr_rd = 1'b1;
          state_d    = S_NCHK;
        end else begin
          cmd.dir_inc = 1'b1;
        end
      end
      S_NCHK: begin
        cmd.nbr_mark = stat_i.nbr_free;
        cmd.dir_inc  = 1'b1;
        state_d      = S_NRD;
      end
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.res_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (cmd.item_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv || cmd.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RSWEEP;
      abort_q     <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      abort_q     <= abort_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  // a load/query result never sits in the staging register during a fill
  `ASSERT_CLK(a_no_s1_in_fill,
              (state_q != S_IDLE && state_q != S_RSWEEP) |-> !s1_valid_q)
  // the post-reset clear runs once only
  `ASSERT_CLK(a_sweep_once, (state_q != S_RSWEEP) |=> (state_q != S_RSWEEP))

endmodule

FILE: design/bffm_dp.sv
`timescale 1ns / 1ps
// Flood-fill datapath: wall, visited and queue memories, pointers, output register.
// Depends on bffm_pkg, bffm_ram and assert_macros.svh.
`include "assert_macros.svh"
module bffm_dp #(
  parameter int unsigned IMAGE_WIDTH  = 128,
  parameter int unsigned IMAGE_HEIGHT = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [bffm_pkg::COORD_W-1:0]  col_i,
  input  logic [bffm_pkg::COORD_W-1:0]  row_i,
  input  logic                          wall_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  bffm_pkg::cmd_t                cmd_i,
  output bffm_pkg::stat_t               stat_o,
  output logic                          status_o,
  output logic                          mask_bit_o,
  output logic [bffm_pkg::COUNT_W-1:0]  fill_count_o
);

  localparam int unsigned CW    = $clog2(IMAGE_WIDTH);
  localparam int unsigned RW    = $clog2(IMAGE_HEIGHT);
  localparam int unsigned AW    = CW + RW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned PW    = AW + 1;
  localparam logic [CW-1:0] COL_LAST = CW'(IMAGE_WIDTH - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(IMAGE_HEIGHT - 1);
  localparam logic [PW-1:0] TAIL_MAX = PW'(IMAGE_WIDTH * IMAGE_HEIGHT);

  logic [bffm_pkg::COORD_EXT_W-1:0] col_ext, row_ext;
  logic          in_inside;
  logic [AW-1:0] in_addr;

  logic          mode_q;
  logic [AW-1:0] sweep_q;
  logic [PW-1:0] head_q, tail_q, clr_q;
  logic [bffm_pkg::DIR_W-1:0] dir_q;
  logic          qflag_q;
  logic [CW-1:0] start_col_q, center_col_q;
  logic [RW-1:0] start_row_q, center_row_q;
  logic          start_in_q;
  logic [AW-1:0] start_addr;

  bffm_pkg::step_t dc, dr;
  logic [CW-1:0] nbr_col;
  logic [RW-1:0] nbr_row;
  logic          col_ok, row_ok;
  logic [AW-1:0] nbr_addr;

  logic          wall_we, wall_re, wall_rdata;
  logic [AW-1:0] wall_raddr;
  logic          vis_we, vis_wdata, vis_re, vis_rdata;
  logic [AW-1:0] vis_waddr, vis_raddr;
  logic          q_we, q_re;
  logic [AW-1:0] q_waddr, q_wdata, q_raddr, q_rdata;

  logic [31:0]                  tail_ext;
  logic [bffm_pkg::COUNT_W-1:0] count_sat;
  logic                         status_q, mbit_q;
  logic [bffm_pkg::COUNT_W-1:0] count_q;

  // input position
  assign col_ext   = bffm_pkg::COORD_EXT_W'(col_i);
  assign row_ext   = bffm_pkg::COORD_EXT_W'(row_i);
  assign in_inside = (col_ext < bffm_pkg::COORD_EXT_W'(IMAGE_WIDTH)) &&
                     (row_ext < bffm_pkg::COORD_EXT_W'(IMAGE_HEIGHT));
  assign in_addr    = {row_ext[RW-1:0], col_ext[CW-1:0]};
  assign start_addr = {start_row_q, start_col_q};

  // neighbour of the centre pixel in the current direction
  assign dc = bffm_pkg::STEP_DC[dir_q[2:0]];
  assign dr = bffm_pkg::STEP_DR[dir_q[2:0]];

  always_comb begin
    unique case (dc)
      bffm_pkg::STEP_POS: begin
        nbr_col = center_col_q + 1'b1;
        col_ok  = (center_col_q != COL_LAST);
      end
      bffm_pkg::STEP_NEG: begin
        nbr_col = center_col_q - 1'b1;
        col_ok  = (center_col_q != '0);
      end
      default: begin
        nbr_col = center_col_q;
        col_ok  = 1'b1;
      end
    endcase
    unique case (dr)
      bffm_pkg::STEP_POS: begin
        nbr_row = center_row_q + 1'b1;
        row_ok  = (center_row_q != ROW_LAST);
      end
      bffm_pkg::STEP_NEG: begin
        nbr_row = center_row_q - 1'b1;
        row_ok  = (center_row_q != '0);
      end
      default: begin
        nbr_row = center_row_q;
        row_ok  = 1'b1;
      end
    endcase
  end

  assign nbr_addr = {nbr_row, nbr_col};

  // memory port steering
  assign wall_we    = cmd_i.item_acc && cmd_i.is_load && in_inside;
  assign wall_re    = cmd_i.start_rd || cmd_i.nbr_rd;
  assign wall_raddr = cmd_i.nbr_rd ? nbr_addr : start_addr;

  assign vis_we    = cmd_i.sweep_wr || cmd_i.clr_wr || cmd_i.start_mark || cmd_i.nbr_mark;
  assign vis_wdata = cmd_i.start_mark || cmd_i.nbr_mark;
  assign vis_re    = (cmd_i.item_acc && cmd_i.is_query) || cmd_i.nbr_rd;
  assign vis_raddr = cmd_i.nbr_rd ? nbr_addr : in_addr;

  always_comb begin
    priority if (cmd_i.sweep_wr) begin
      vis_waddr = sweep_q;
    end else if (cmd_i.clr_wr) begin
      vis_waddr = q_rdata;
    end else if (cmd_i.start_mark) begin
      vis_waddr = start_addr;
    end else begin
      vis_waddr = nbr_addr;
    end
  end

  assign q_we    = cmd_i.start_mark || cmd_i.nbr_mark;
  assign q_waddr = tail_q[AW-1:0];
  assign q_wdata = cmd_i.start_mark ? start_addr : nbr_addr;
  assign q_re    = cmd_i.clr_rd || cmd_i.pop_rd;
  assign q_raddr = cmd_i.clr_rd ? clr_q[AW-1:0] : head_q[AW-1:0];

  bffm_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_wall_ram (
    .clk_i   (clk_i),
    .we_i    (wall_we),
    .waddr_i (in_addr),
    .wdata_i (wall_i),
    .re_i    (wall_re),
    .raddr_i (wall_raddr),
    .rdata_o (wall_rdata)
  );

  bffm_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_vis_ram (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .waddr_i (vis_waddr),
    .wdata_i (vis_wdata),
    .re_i    (vis_re),
    .raddr_i (vis_raddr),
    .rdata_o (vis_rdata)
  );

  bffm_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .re_i    (q_re),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      sweep_q    <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      clr_q      <= '0;
      dir_q      <= '0;
      qflag_q    <= 1'b0;
      start_in_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (cmd_i.sweep_wr) begin
        sweep_q <= sweep_q + 1'b1;
      end
      if (cmd_i.clr_reset) begin
        clr_q <= '0;
      end else if (cmd_i.clr_wr) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.tail_clr) begin
        head_q <= '0;
        tail_q <= '0;
      end else begin
        if (q_we) begin
          tail_q <= tail_q + 1'b1;
        end
        if (cmd_i.cen_load) begin
          head_q <= head_q + 1'b1;
        end
      end
      if (cmd_i.cen_load) begin
        dir_q <= '0;
      end else if (cmd_i.dir_inc) begin
        dir_q <= dir_q + 1'b1;
      end
      if (cmd_i.item_acc) begin
        qflag_q <= cmd_i.is_query && in_inside;
      end
      if (cmd_i.fill_acc) begin
        start_in_q <= in_inside;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_acc) begin
      start_col_q <= col_ext[CW-1:0];
      start_row_q <= row_ext[RW-1:0];
    end
    if (cmd_i.cen_load) begin
      center_col_q <= q_rdata[CW-1:0];
      center_row_q <= q_rdata[AW-1:CW];
    end
    if (cmd_i.s1_out) begin
      status_q <= 1'b0;
      mbit_q   <= qflag_q && vis_rdata;
      count_q  <= '0;
    end else if (cmd_i.res_load) begin
      status_q <= cmd_i.abort;
      mbit_q   <= 1'b0;
      count_q  <= count_sat;
    end
  end

  assign tail_ext  = 32'(tail_q);
  assign count_sat = (tail_ext > 32'(bffm_pkg::COUNT_MAX)) ? bffm_pkg::COUNT_MAX
                                                           : tail_ext[bffm_pkg::COUNT_W-1:0];

  assign stat_o.sweep_last    = &sweep_q;
  assign stat_o.clr_done      = (clr_q == tail_q);
  assign stat_o.start_inside  = start_in_q;
  assign stat_o.start_wall    = wall_rdata;
  assign stat_o.queue_empty   = (head_q == tail_q);
  assign stat_o.center_corner = (q_rdata == '0);
  assign stat_o.dir_done      = (dir_q == (mode_q ? bffm_pkg::DIRS_EIGHT
                                                  : bffm_pkg::DIRS_FOUR));
  assign stat_o.nbr_inside    = col_ok && row_ok;
  assign stat_o.nbr_free      = !wall_rdata && !vis_rdata;

  assign status_o     = status_q;
  assign mask_bit_o   = mbit_q;
  assign fill_count_o = count_q;

  `ASSERT_CLK(a_tail_bound, tail_q <= TAIL_MAX)
  `ASSERT_CLK(a_head_le_tail, head_q <= tail_q)
  `ASSERT_NEVER(a_mark_blocked, cmd_i.nbr_mark && (wall_rdata || vis_rdata))

endmodule

FILE: tb/bfs_flood_fill_mask_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the flood-fill mask block: directed table, then random traffic.
// Depends on bffm_pkg and bfs_flood_fill_mask; predicts untyped results with its own BFS.
module bfs_flood_fill_mask_tb;

  localparam int IMG_W = 128;
  localparam int IMG_H = 128;
  localparam int PIXELS = IMG_W * IMG_H;
  localparam logic [bffm_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

  localparam int IDLE_PCT = 6;        // chance of a gap per cycle, in percent
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int SETTLE_CYCLES = 16;  // quiet cycles before a register write and at the end
  localparam int SEG_ITEMS = 250;     // random items per register setting
  localparam int WIN = 10;            // side of each random work window
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  // Step table, orthogonal neighbours first
  localparam int DIR_DC [8] = '{1, -1, 0, 0, 1, 1, -1, -1};
  localparam int DIR_DR [8] = '{0, 0, 1, -1, 1, -1, 1, -1};

  // Fills and in-window loads are confined to three small windows, each ringed by wall
  // pixels or the image edge, so every fill only reads loaded pixels and regions stay small.
  // Window 0 holds the corner, window 1 the far edges.
  localparam int WIN_C [3] = '{0, 118, 60};
  localparam int WIN_R [3] = '{0, 118, 90};

  typedef struct packed {
    logic                         status;
    logic                         mask_bit;
    logic [bffm_pkg::COUNT_W-1:0] fill_count;
  } result_t;

  // What to do before a directed row is offered
  typedef enum logic [1:0] {
    PREP_NONE,
    PREP_WINDOWS,  // load the three windows open, their rings and the corner as wall
    PREP_EIGHT     // switch to eight neighbours
  } prep_e;

  typedef struct packed {
    prep_e                         prep;
    logic [bffm_pkg::OPCODE_W-1:0] op;
    logic [bffm_pkg::COORD_W-1:0]  col;
    logic [bffm_pkg::COORD_W-1:0]  row;
    logic                          wall;
    logic                          typed;  // expected result given below, else predicted
    logic                          st;
    logic                          mb;
    logic [bffm_pkg::COUNT_W-1:0]  cnt;
  } dir_row_t;

  localparam int N_DIRECTED = 28;
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    // fresh out of reset: mask empty, unused opcode answers zeros
    '{PREP_NONE,    bffm_pkg::OP_QUERY, 7'd0,   7'd0,   1'b0, 1'b1, 1'b0, 1'b0, 15'd0},
    '{PREP_NONE,    bffm_pkg::OP_QUERY, 7'd127, 7'd127, 1'b1, 1'b1, 1'b0, 1'b0, 15'd0},
    '{PREP_NONE,    OP_UNUSED,          7'd127, 7'd127, 1'b1, 1'b1, 1'b0, 1'b0, 15'd0},
    '{PREP_NONE,    OP_UNUSED,          7'd0,   7'd0,   1'b0, 1'b1, 1'b0, 1'b0, 15'd0},
    // walled windows, corner walled: fill the far window
    '{PREP_WINDOWS, bffm_pkg::OP_FILL,  7'd127, 7'd127, 1'b0, 1'b0, 1'b0, 1'b0, 15'd0},
    '{PREP_NONE,    bffm_pkg::OP_QUERY, 7'd0,   7'd0,   1'b0, 1'b1, 1'b0, 1'b0, 15'd0},
    '{PREP_NONE,    bffm_pkg::OP_QUERY, 7'd118, 7'd118, 1'b1, 1'b0, 1'b0, 1'b0, 15'd0},
    '{PREP_NONE,    bffm_pkg::OP_QUERY, 7'd117, 7'd117, 1'b0, 1'b0, 1'b0, 1'b0, 15'd0},
    // a new fill wipes the old region
    '{PREP_NONE,    bffm_pkg::OP_FILL,  7'd64,  7'd95,  1'b0, 1'b0, 1'b0, 1'b0, 15'd0},
    '{PREP_NONE,    bffm_pkg::OP_QUERY, 7'd127, 7'd127, 1'b0, 1'b1, 1'b0, 1'b0, 15'd0},
    // start on a wall wipes the mask and marks nothing
    '{PREP_NONE,    bffm_pkg::OP_FILL,  7'd0,   7'd0,   1'b1, 1'b1, 1'b0, 1'b0, 15'd0},
    '{PREP_NONE,    bffm_pkg::OP_QUERY, 7'd64,  7'd95,  1'b0, 1'b1, 1'b0, 1'b0, 15'd0},
    // start at the corner aborts straight away
    '{PREP_NONE,    bffm_pkg::OP_LOAD,  7'd0,   7'd0,   1'b0, 1'b1, 1'b0, 1'b0, 15'd0},
    '{PREP_NONE,    bffm_pkg::OP_FILL,  7'd0,   7'd0,   1'b0, 1'b1, 1'b1, 1'b0, 15'd0},
    '{PREP_NONE,    bffm_pkg::OP_QUERY, 7'd0,   7'd0,   1'b1, 1'b1, 1'b0, 1'b0, 15'd0},
    // walk that reaches the corner aborts and leaves an empty mask
    '{PREP_NONE,    bffm_pkg::OP_FILL,  7'd9,   7'd9,   1'b0, 1'b0, 1'b0, 1'b0, 15'd0},
    '{PREP_NONE,    bffm_pkg::OP_QUERY, 7'd9,   7'd9,   1'b0, 1'b1, 1'b0, 1'b0, 15'd0},
    // eight neighbours: corner reachable only on the diagonal
    '{PREP_EIGHT,   bffm_pkg::OP_LOAD,  7'd1,   7'd0,   1'b1, 1'b1, 1'b0, 1'b0, 15'd0},
    '{PREP_NONE,    bffm_pkg::OP_LOAD,  7'd0,   7'd1,   1'b1, 1'b1, 1'b0, 1'b0, 15'd0},
    '{PREP_NONE,    bffm_pkg::OP_FILL,  7'd1,   7'd1,   1'b0, 1'b0, 1'b0, 1'b0, 15'd0},
    '{PREP_NONE,    bffm_pkg::OP_QUERY, 7'd1,   7'd1,   1'b0, 1'b0, 1'b0, 1'b0, 15'd0},
    // single open pixel in the far corner
    '{PREP_NONE,    bffm_pkg::OP_LOAD,  7'd126, 7'd127, 1'b1, 1'b1, 1'b0, 1'b0, 15'd0},
    '{PREP_NONE,    bffm_pkg::OP_LOAD,  7'd127, 7'd126, 1'b1, 1'b1, 1'b0, 1'b0, 15'd0},
    '{PREP_NONE,    bffm_pkg::OP_LOAD,  7'd126, 7'd126, 1'b1, 1'b1, 1'b0, 1'b0, 15'd0},
    '{PREP_NONE,    bffm_pkg::OP_FILL,  7'd127, 7'd127, 1'b0, 1'b1, 1'b0, 1'b0, 15'd1},
    '{PREP_NONE,    bffm_pkg::OP_QUERY, 7'd127, 7'd127, 1'b0, 1'b1, 1'b0, 1'b1, 15'd0},
    '{PREP_NONE,    OP_UNUSED,          7'd5,   7'd5,   1'b1, 1'b1, 1'b0, 1'b0, 15'd0},
    '{PREP_NONE,    bffm_pkg::OP_QUERY, 7'd127, 7'd127, 1'b1, 1'b0, 1'b0, 1'b0, 15'd0}
  };

  // Clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  // Block inputs, known from time zero
  logic                          in_valid_i = 1'b0;
  logic [bffm_pkg::OPCODE_W-1:0] opcode_i = '0;
  logic [bffm_pkg::COORD_W-1:0]  col_i = '0;
  logic [bffm_pkg::COORD_W-1:0]  row_i = '0;
  logic                          wall_i = 1'b0;
  logic                          out_ready_i = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic                          cfg_wdata_i = 1'b0;

  logic                          in_ready_o;
  logic                          out_valid_o;
  logic                          status_o;
  logic                          mask_bit_o;
  logic [bffm_pkg::COUNT_W-1:0]  fill_count_o;

  bfs_flood_fill_mask dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .col_i        (col_i),
    .row_i        (row_i),
    .wall_i       (wall_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .mask_bit_o   (mask_bit_o),
    .fill_count_o (fill_count_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Predictor state: own copy of the image, the mask, the BFS queue and the mode
  bit      wall_img [PIXELS];
  bit      seen_img [PIXELS];
  int      bfs_q [PIXELS];
  logic    mode_q = 1'b0;

  result_t pending_results [$];

  // Shared between sender and receiver, plus the receiver's hold-off state
  logic    calm = 1'b0;      // no random gaps on either side
  logic    hold_req = 1'b0;  // sender asks for the long hold-off
  logic    hold_done = 1'b0;
  int      hold_left = 0;

  int      mismatches = 0;
  int      results_checked = 0;
  int      items_sent = 0;
  int      fills_sent = 0;
  int      aborts_sent = 0;
  int      mask_hits = 0;
  int      mode_writes = 0;
  int unsigned cycle_count = 0;

  task automatic note_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatches++;
    $display("%0t: mismatch on %s: got %0d, want %0d (result %0d)",
             $time, what, got, want, results_checked);
  endtask

  // Result of one item, updating the predicted image and mask as the block would
  function automatic result_t flood_outcome(logic [bffm_pkg::OPCODE_W-1:0] op,
                                            logic [bffm_pkg::COORD_W-1:0] c,
                                            logic [bffm_pkg::COORD_W-1:0] r, logic w);
    result_t res;
    int      head, tail, marks, ndirs, pc, pr, nc, nr, at;
    bit      aborted;
    res = '0;
    at = int'(r) * IMG_W + int'(c);
    case (op)
      bffm_pkg::OP_LOAD:  wall_img[at] = w;
      bffm_pkg::OP_QUERY: res.mask_bit = seen_img[at];
      bffm_pkg::OP_FILL: begin
        seen_img = '{default: 1'b0};
        head = 0;
        tail = 0;
        marks = 0;
        aborted = 1'b0;
        ndirs = mode_q ? 8 : 4;
        if (!wall_img[at]) begin
          seen_img[at] = 1'b1;
          bfs_q[tail] = at;
          tail++;
          marks++;
        end
        while (head < tail && !aborted) begin
          pc = bfs_q[head] % IMG_W;
          pr = bfs_q[head] / IMG_W;
          if (pc == 0 && pr == 0) begin
            aborted = 1'b1;
          end else begin
            head++;
            for (int d = 0; d < ndirs; d++) begin
              nc = pc + DIR_DC[d];
              nr = pr + DIR_DR[d];
              if (nc >= 0 && nr >= 0 && nc < IMG_W && nr < IMG_H) begin
                at = nr * IMG_W + nc;
                if (!seen_img[at] && !wall_img[at]) begin
                  seen_img[at] = 1'b1;
                  bfs_q[tail] = at;
                  tail++;
                  marks++;
                end
              end
            end
          end
        end
        // corner reached: the whole mask goes
        if (aborted) begin
          seen_img = '{default: 1'b0};
          marks = 0;
        end
        res.status = aborted;
        res.fill_count = (marks > int'(bffm_pkg::COUNT_MAX)) ? bffm_pkg::COUNT_MAX
                                                             : bffm_pkg::COUNT_W'(marks);
      end
      default: ;
    endcase
    return res;
  endfunction

  // Offer one item, hold it until the transfer, then queue what it should answer.
  // Called at a rising edge; leaves off at the edge of the transfer.
  task automatic offer_item(logic [bffm_pkg::OPCODE_W-1:0] op,
                            logic [bffm_pkg::COORD_W-1:0] c,
                            logic [bffm_pkg::COORD_W-1:0] r, logic w,
                            logic typed = 1'b0, result_t fixed = '0);
    result_t res;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    col_i <= c;
    row_i <= r;
    wall_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // transfer at this edge
    res = flood_outcome(op, c, r, w);
    pending_results.push_back(typed ? fixed : res);
    items_sent++;
    if (op == bffm_pkg::OP_FILL) begin
      fills_sent++;
      if (res.status) aborts_sent++;
    end
    if (op == bffm_pkg::OP_QUERY && res.mask_bit) mask_hits++;
  endtask

  // Drain, let the block settle, then write the neighbour mode
  task automatic set_mode(logic m);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_q = m;
    mode_writes++;
  endtask

  // Load each window open, its surrounding ring and the corner pixel as wall
  task automatic build_windows();
    for (int w = 0; w < 3; w++)
      for (int r = WIN_R[w] - 1; r <= WIN_R[w] + WIN; r++)
        for (int c = WIN_C[w] - 1; c <= WIN_C[w] + WIN; c++)
          if (r >= 0 && c >= 0 && r < IMG_H && c < IMG_W)
            offer_item(bffm_pkg::OP_LOAD, bffm_pkg::COORD_W'(c), bffm_pkg::COORD_W'(r),
                       (r == WIN_R[w] - 1) || (r == WIN_R[w] + WIN) ||
                       (c == WIN_C[w] - 1) || (c == WIN_C[w] + WIN) ||
                       (r == 0 && c == 0));
  endtask

  // Random traffic under one mode setting. Loads and fills land inside the
  // windows so that regions grow and shrink; wall noise and queries go anywhere.
  task automatic run_segment(int n_items, logic m, logic quiet, logic with_hold);
    set_mode(m);
    calm = quiet;
    for (int i = 0; i < n_items; i++) begin
      int                           pick, win;
      logic [bffm_pkg::COORD_W-1:0] wc, wr, ac, ar;
      pick = $urandom_range(99);
      win = $urandom_range(2);
      wc = bffm_pkg::COORD_W'(WIN_C[win] + $urandom_range(WIN - 1));
      wr = bffm_pkg::COORD_W'(WIN_R[win] + $urandom_range(WIN - 1));
      ac = bffm_pkg::COORD_W'($urandom_range(IMG_W - 1));
      ar = bffm_pkg::COORD_W'($urandom_range(IMG_H - 1));
      // receiver stops for a long while; the held output backs up the block until input stalls
      if (with_hold && i == 40) hold_req = 1'b1;
      if (pick < 45)
        offer_item(bffm_pkg::OP_LOAD, wc, wr, $urandom_range(99) < 35);
      else if (pick < 50)
        offer_item(bffm_pkg::OP_LOAD, ac, ar, 1'b1);
      else if (pick < 64)
        offer_item(bffm_pkg::OP_FILL, wc, wr, 1'($urandom_range(1)));
      else if (pick < 94) begin
        if ($urandom_range(9) < 7)
          offer_item(bffm_pkg::OP_QUERY, wc, wr, 1'($urandom_range(1)));
        else
          offer_item(bffm_pkg::OP_QUERY, ac, ar, 1'($urandom_range(1)));
      end else
        offer_item(OP_UNUSED, ac, ar, 1'($urandom_range(1)));
    end
    calm = 1'b0;
  endtask

  // Receiver: check each result transfer, then decide ready for the next edge
  result_t rx_want;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing pending", 16'd1, 16'd0);
      end else begin
        rx_want = pending_results.pop_front();
        if (status_o !== rx_want.status)
          note_mismatch("status", 16'(status_o), 16'(rx_want.status));
        if (mask_bit_o !== rx_want.mask_bit)
          note_mismatch("mask_bit", 16'(mask_bit_o), 16'(rx_want.mask_bit));
        if (fill_count_o !== rx_want.fill_count)
          note_mismatch("fill_count", 16'(fill_count_o), 16'(rx_want.fill_count));
        results_checked++;
      end
    end
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stimulus
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // block clears its visited store first; the sender simply waits on ready
    set_mode(1'b0);

    for (int i = 0; i < N_DIRECTED; i++) begin
      case (DIRECTED[i].prep)
        PREP_WINDOWS: build_windows();
        PREP_EIGHT:   set_mode(1'b1);
        default: ;
      endcase
      offer_item(DIRECTED[i].op, DIRECTED[i].col, DIRECTED[i].row, DIRECTED[i].wall,
                 DIRECTED[i].typed,
                 result_t'{status: DIRECTED[i].st, mask_bit: DIRECTED[i].mb,
                           fill_count: DIRECTED[i].cnt});
    end

    // Random part: mode alternates, one stretch without gaps, one long hold-off
    run_segment(SEG_ITEMS, 1'b0, 1'b0, 1'b0);
    run_segment(SEG_ITEMS, 1'b1, 1'b1, 1'b0);
    run_segment(SEG_ITEMS, 1'b0, 1'b0, 1'b1);
    run_segment(SEG_ITEMS, 1'b1, 1'b0, 1'b0);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d items: %0d fills (%0d aborted at the corner), %0d mask hits on query",
             items_sent, fills_sent, aborts_sent, mask_hits);
    $display("Checked %0d results over %0d mode writes, %0d mismatches",
             results_checked, mode_writes, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
